### hdl/otr_pkg.sv
// otr_pkg: shared types, codes and constants of the overwriting trace ring
// used by every module of the ring but otr_ram; no dependencies
`timescale 1ns / 1ps
package otr_pkg;

  localparam int DEPTH_DEF    = 32;
  localparam int QDEPTH       = 2;
  localparam int OVF_FLAG_BIT = 10;
  localparam int REC_W        = 64;
  localparam logic [15:0] DROP_MAX = 16'hFFFF;
  localparam logic [15:0] CUR_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_OVERFLOW = 2'd1,
    KIND_PEEK     = 2'd2,
    KIND_ACK      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_PEEK = 2'd1,
    OP_ACK  = 2'd2
  } op_t;

  // stored layout: stage 7:0, flags 15:8, tick 31:16, value 63:32
  typedef struct packed {
    logic [31:0] value;
    logic [15:0] tick;
    logic [7:0]  flags;
    logic [7:0]  stage;
  } rec_t;

  typedef struct packed {
    op_t         op;
    rec_t        rec;
    logic [15:0] arg;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hdl/overwriting_trace_ring_core.sv
// overwriting_trace_ring_core: top level of the overwriting trace ring
// depends on otr_pkg, otr_front, otr_queue, otr_back (and otr_ram below it)
// out_strobe is registered; record, overflow and acknowledge requests pass
//   the command queue and the back end, a peek also the registered ram read
// throughput: 1 request per cycle while busy is low; a peek holds the back end
//   through its ram read, busy rises once the 2-entry command queue is full;
//   results cannot stall; reset (sync, rst_n low) clears cursors, counters,
//   queue and stage register; store contents are undefined until written
`timescale 1ns / 1ps
module overwriting_trace_ring_core #(
  parameter int DEPTH = otr_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request side
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_stage,
  input  logic [7:0]                 in_flag_bits,
  input  logic [31:0]                in_payload_value,
  input  logic [15:0]                in_identity,
  input  logic [15:0]                in_overflow_payload,
  input  logic [15:0]                in_tick,
  input  logic [15:0]                in_peek_index,
  input  logic [15:0]                in_ack_count,
  // overflow stage code register
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  // result side, one pulse per request
  output logic                       out_strobe,
  output logic                       out_peek_valid,
  output logic [7:0]                 out_stage,
  output logic [7:0]                 out_flags,
  output logic [15:0]                out_tick,
  output logic [31:0]                out_value,
  output logic [$clog2(DEPTH+1)-1:0] out_pending_count,
  output logic [15:0]                out_dropped_count
);
  import otr_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;
  rec_t    res_rec;

  // front: request decode, overflow record packing, stage register
  otr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_stage            (in_stage),
    .in_flag_bits        (in_flag_bits),
    .in_payload_value    (in_payload_value),
    .in_identity         (in_identity),
    .in_overflow_payload (in_overflow_payload),
    .in_tick             (in_tick),
    .in_peek_index       (in_peek_index),
    .in_ack_count        (in_ack_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .q_full              (q_stat.full),
    .push                (push),
    .push_cmd            (push_cmd)
  );

  // decoupling queue, keeps request order
  otr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // back: cursors, drop counter, record store, result register
  otr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_stat.empty),
    .head_cmd          (head_cmd),
    .pop               (pop),
    .out_strobe        (out_strobe),
    .out_peek_valid    (out_peek_valid),
    .out_rec           (res_rec),
    .out_pending_count (out_pending_count),
    .out_dropped_count (out_dropped_count)
  );

  // record fields are zero unless a peek hit a pending record
  assign out_stage = res_rec.stage;
  assign out_flags = res_rec.flags;
  assign out_tick  = res_rec.tick;
  assign out_value = res_rec.value;

endmodule

### hdl/otr_ram.sv
// otr_ram: generic simple dual-port ram, one write and one registered read
// no package dependencies
`timescale 1ns / 1ps
module otr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/otr_queue.sv
// otr_queue: short command queue between the front and back parts
// depends on otr_pkg for cmd_t, q_stat_t and the queue depth
`timescale 1ns / 1ps
module otr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  otr_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output otr_pkg::cmd_t  head_cmd,
  output otr_pkg::q_stat_t stat
);
  import otr_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t            slot_r [QDEPTH];
  logic [QAW-1:0]  wptr_r, wptr_nxt;
  logic [QAW-1:0]  rptr_r, rptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  assign head_cmd   = slot_r[rptr_r];
  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### hdl/otr_front.sv
// otr_front: takes requests, holds the overflow stage register and turns
// each request into a queue command; depends on otr_pkg
`timescale 1ns / 1ps
module otr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_kind,
  input  logic [7:0]    in_stage,
  input  logic [7:0]    in_flag_bits,
  input  logic [31:0]   in_payload_value,
  input  logic [15:0]   in_identity,
  input  logic [15:0]   in_overflow_payload,
  input  logic [15:0]   in_tick,
  input  logic [15:0]   in_peek_index,
  input  logic [15:0]   in_ack_count,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data,
  input  logic          q_full,
  output logic          push,
  output otr_pkg::cmd_t push_cmd
);
  import otr_pkg::*;

  logic [7:0] ovf_stage_r, ovf_stage_nxt;

  assign cfg_ready     = 1'b1;
  assign ovf_stage_nxt = (cfg_valid && cfg_ready) ? cfg_data : ovf_stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_stage_r <= '0;
    end else begin
      ovf_stage_r <= ovf_stage_nxt;
    end
  end

  assign busy = q_full;
  assign push = start && !busy;

  always_comb begin
    push_cmd.op        = OP_PUT;
    push_cmd.rec.value = in_payload_value;
    push_cmd.rec.tick  = in_tick;
    push_cmd.rec.flags = in_flag_bits;
    push_cmd.rec.stage = in_stage;
    push_cmd.arg       = '0;
    case (kind_t'(in_kind))
      KIND_RECORD: begin
        push_cmd.op = OP_PUT;
      end
      KIND_OVERFLOW: begin
        // identity in the low half, raw payload in the high half
        push_cmd.op        = OP_PUT;
        push_cmd.rec.value = {in_overflow_payload, in_identity};
        push_cmd.rec.flags = {7'd0, in_identity[OVF_FLAG_BIT]};
        push_cmd.rec.stage = ovf_stage_r;
      end
      KIND_PEEK: begin
        push_cmd.op  = OP_PEEK;
        push_cmd.arg = in_peek_index;
      end
      KIND_ACK: begin
        push_cmd.op  = OP_ACK;
        push_cmd.arg = in_ack_count;
      end
      default: begin
        push_cmd.op = OP_PUT;
      end
    endcase
  end

endmodule

### hdl/otr_back.sv
// otr_back: executes queued commands on the record store and the cursors
// and registers the result; depends on otr_pkg and otr_ram
`timescale 1ns / 1ps
module otr_back #(
  parameter int DEPTH = otr_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  otr_pkg::cmd_t              head_cmd,
  output logic                       pop,
  output logic                       out_strobe,
  output logic                       out_peek_valid,
  output otr_pkg::rec_t              out_rec,
  output logic [$clog2(DEPTH+1)-1:0] out_pending_count,
  output logic [15:0]                out_dropped_count
);
  import otr_pkg::*;

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int SW       = AW + 2;
  localparam int WRAP_REM = 65536 % DEPTH;
  localparam logic [SW-1:0] WRAP_ADJ = SW'(DEPTH - WRAP_REM);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_READ = 2'b10
  } state_t;

  // slot of (cursor + delta) mod 2^16 mod depth, given the cursor's slot
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] slot,
                                             input logic [CW-1:0] delta,
                                             input logic          wrapped);
    logic [SW-1:0] t;
    t = SW'(slot) + SW'(delta) + (wrapped ? WRAP_ADJ : '0);
    if (t >= DEPTH_S) t = t - DEPTH_S;
    if (t >= DEPTH_S) t = t - DEPTH_S;
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] slot,
                                             input logic          wrapped);
    logic [AW-1:0] r;
    r = (wrapped || slot == LAST) ? '0 : slot + 1'b1;
    return r;
  endfunction

  state_t        state_r, state_nxt;
  logic [15:0]   wp_r, wp_nxt;
  logic [15:0]   fp_r, fp_nxt;
  logic [AW-1:0] wslot_r, wslot_nxt;
  logic [AW-1:0] fslot_r, fslot_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   drop_r, drop_nxt;
  logic          pv_r, pv_nxt;
  logic          strobe_r, strobe_nxt;
  logic          res_pv_r, res_pv_nxt;
  rec_t          res_rec_r, res_rec_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [REC_W-1:0] rdata;
  logic [16:0]   sum17;
  logic [CW-1:0] ack_amt;

  otr_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (head_cmd.rec),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fp_nxt      = fp_r;
    wslot_nxt   = wslot_r;
    fslot_nxt   = fslot_r;
    cnt_nxt     = cnt_r;
    drop_nxt    = drop_r;
    pv_nxt      = pv_r;
    strobe_nxt  = 1'b0;
    res_pv_nxt  = 1'b0;
    res_rec_nxt = '0;
    pop         = 1'b0;
    we          = 1'b0;
    waddr       = wslot_r;
    raddr       = '0;
    sum17       = '0;
    ack_amt     = '0;
    case (state_r)
      S_RUN: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head_cmd.op)
            OP_PUT: begin
              we         = 1'b1;
              wp_nxt     = wp_r + 1'b1;
              wslot_nxt  = slot_inc(wslot_r, wp_r == CUR_MAX);
              strobe_nxt = 1'b1;
              if (cnt_r == FULL_CNT) begin
                // ring full: oldest record is lost
                fp_nxt    = fp_r + 1'b1;
                fslot_nxt = slot_inc(fslot_r, fp_r == CUR_MAX);
                if (drop_r != DROP_MAX) begin
                  drop_nxt = drop_r + 1'b1;
                end
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_ACK: begin
              ack_amt    = (head_cmd.arg > 16'(cnt_r)) ? cnt_r : CW'(head_cmd.arg);
              sum17      = {1'b0, fp_r} + 17'(ack_amt);
              fp_nxt     = sum17[15:0];
              fslot_nxt  = slot_add(fslot_r, ack_amt, sum17[16]);
              cnt_nxt    = cnt_r - ack_amt;
              strobe_nxt = 1'b1;
            end
            OP_PEEK: begin
              sum17     = {1'b0, fp_r} + {1'b0, head_cmd.arg};
              pv_nxt    = head_cmd.arg < 16'(cnt_r);
              raddr     = slot_add(fslot_r, CW'(head_cmd.arg), sum17[16]);
              state_nxt = S_READ;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        strobe_nxt  = 1'b1;
        res_pv_nxt  = pv_r;
        res_rec_nxt = pv_r ? rec_t'(rdata) : '0;
        state_nxt   = S_RUN;
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RUN;
      wp_r     <= '0;
      fp_r     <= '0;
      wslot_r  <= '0;
      fslot_r  <= '0;
      cnt_r    <= '0;
      drop_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      fp_r     <= fp_nxt;
      wslot_r  <= wslot_nxt;
      fslot_r  <= fslot_nxt;
      cnt_r    <= cnt_nxt;
      drop_r   <= drop_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_r      <= pv_nxt;
    res_pv_r  <= res_pv_nxt;
    res_rec_r <= res_rec_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_peek_valid    = res_pv_r;
  assign out_rec           = res_rec_r;
  assign out_pending_count = cnt_r;
  assign out_dropped_count = drop_r;

endmodule

### test/trace_ring_checker.sv
// trace_ring_checker: watches the request, register and result channels of the trace ring
// keeps its own copy of the ring, predicts each result and compares it; uses otr_pkg
`timescale 1ns / 1ps
module trace_ring_checker #(
  parameter int DEPTH = otr_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [7:0]                 in_stage,
  input  logic [7:0]                 in_flag_bits,
  input  logic [31:0]                in_payload_value,
  input  logic [15:0]                in_identity,
  input  logic [15:0]                in_overflow_payload,
  input  logic [15:0]                in_tick,
  input  logic [15:0]                in_peek_index,
  input  logic [15:0]                in_ack_count,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [7:0]                 cfg_data,
  input  logic                       out_strobe,
  input  logic                       out_peek_valid,
  input  logic [7:0]                 out_stage,
  input  logic [7:0]                 out_flags,
  input  logic [15:0]                out_tick,
  input  logic [31:0]                out_value,
  input  logic [$clog2(DEPTH+1)-1:0] out_pending_count,
  input  logic [15:0]                out_dropped_count,
  input  logic                       end_of_test,
  output int                         results_due,
  output int                         fail_count
);
  import otr_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic          hit;
    logic [7:0]    stage;
    logic [7:0]    flags;
    logic [15:0]   tick;
    logic [31:0]   value;
    logic [PW-1:0] pending;
    logic [15:0]   dropped;
  } trace_result_t;

  rec_t          ring_copy [DEPTH];
  logic [15:0]   wr_cursor;
  logic [15:0]   rd_cursor;
  logic [15:0]   drops_seen;
  logic [7:0]    ovf_stage;
  logic          end_seen;
  trace_result_t trace_results_due [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 30) $display("%0t ns checker: %s", $time, what);
    fail_count++;
  endtask

  // write at the cursor; past depth the oldest pending entry is lost
  task automatic log_record(input rec_t r);
    logic [15:0] fill;
    ring_copy[wr_cursor % DEPTH] = r;
    wr_cursor = wr_cursor + 16'd1;
    fill = wr_cursor - rd_cursor;
    if (fill > DEPTH) begin
      rd_cursor = wr_cursor - 16'(DEPTH);
      if (drops_seen != DROP_MAX) drops_seen = drops_seen + 16'd1;
    end
  endtask

  task automatic predict_trace_result(output trace_result_t want);
    logic [15:0] fill;
    logic [15:0] take;
    rec_t        r;
    want = '0;
    fill = wr_cursor - rd_cursor;
    case (kind_t'(in_kind))
      KIND_RECORD: begin
        r.stage = in_stage;
        r.flags = in_flag_bits;
        r.tick  = in_tick;
        r.value = in_payload_value;
        log_record(r);
      end
      KIND_OVERFLOW: begin
        r.stage = ovf_stage;
        r.flags = {7'd0, in_identity[OVF_FLAG_BIT]};
        r.tick  = in_tick;
        r.value = {in_overflow_payload, in_identity};
        log_record(r);
      end
      KIND_PEEK: begin
        if (in_peek_index < fill) begin
          r = ring_copy[16'(rd_cursor + in_peek_index) % DEPTH];
          want.hit   = 1'b1;
          want.stage = r.stage;
          want.flags = r.flags;
          want.tick  = r.tick;
          want.value = r.value;
        end
      end
      KIND_ACK: begin
        take = (in_ack_count > fill) ? fill : in_ack_count;
        rd_cursor = rd_cursor + take;
      end
      default: begin
      end
    endcase
    fill = wr_cursor - rd_cursor;
    want.pending = (fill > DEPTH) ? PW'(DEPTH) : PW'(fill);
    want.dropped = drops_seen;
  endtask

  // sampled on the falling edge: everything is settled for the next rising edge
  always @(negedge clk) begin
    trace_result_t want;
    if (!rst_n) begin
      wr_cursor  = '0;
      rd_cursor  = '0;
      drops_seen = '0;
      ovf_stage  = '0;
      end_seen   = 1'b0;
      trace_results_due.delete();
    end else begin
      if ($isunknown(out_strobe)) report_mismatch("out_strobe unknown");
      if (out_strobe === 1'b1) begin
        if (trace_results_due.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = trace_results_due.pop_front();
          if (out_peek_valid !== want.hit)
            report_mismatch($sformatf("peek_valid got %b want %b", out_peek_valid, want.hit));
          if (out_stage !== want.stage)
            report_mismatch($sformatf("stage got %h want %h", out_stage, want.stage));
          if (out_flags !== want.flags)
            report_mismatch($sformatf("flags got %h want %h", out_flags, want.flags));
          if (out_tick !== want.tick)
            report_mismatch($sformatf("tick got %h want %h", out_tick, want.tick));
          if (out_value !== want.value)
            report_mismatch($sformatf("value got %h want %h", out_value, want.value));
          if (out_pending_count !== want.pending)
            report_mismatch($sformatf("pending got %0d want %0d",
                                      out_pending_count, want.pending));
          if (out_dropped_count !== want.dropped)
            report_mismatch($sformatf("dropped got %0d want %0d",
                                      out_dropped_count, want.dropped));
        end
      end
      if (cfg_valid && cfg_ready) ovf_stage = cfg_data;
      if (start && !busy) begin
        predict_trace_result(want);
        trace_results_due.push_back(want);
      end
      if (end_of_test && !end_seen) begin
        end_seen = 1'b1;
        if (trace_results_due.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", trace_results_due.size()));
      end
    end
    results_due = trace_results_due.size();
  end

endmodule

### test/testbench.sv
// testbench: drives requests and stage code writes into overwriting_trace_ring_core
// depends on otr_pkg, the ring RTL and trace_ring_checker, which predicts and compares
`timescale 1ns / 1ps
module testbench;
  import otr_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  localparam int HALF_PERIOD = 5;
  localparam int BURST_PUTS  = 400;  // laps the ring many times so the drop count climbs

  // one request, every field of every kind
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  stage;
    logic [7:0]  flag_bits;
    logic [31:0] payload;
    logic [15:0] identity;
    logic [15:0] ovf_payload;
    logic [15:0] tick;
    logic [15:0] peek_index;
    logic [15:0] ack_count;
  } trace_req_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  trace_req_t req_q;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       end_of_test;

  logic                            out_strobe;
  logic                            out_peek_valid;
  logic [7:0]                      out_stage;
  logic [7:0]                      out_flags;
  logic [15:0]                     out_tick;
  logic [31:0]                     out_value;
  logic [$clog2(RING_DEPTH+1)-1:0] out_pending_count;
  logic [15:0]                     out_dropped_count;

  int results_due;
  int fail_count;
  int sender_idle_pct;

  always #HALF_PERIOD clk = ~clk;

  overwriting_trace_ring_core #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (req_q.kind),
    .in_stage           (req_q.stage),
    .in_flag_bits       (req_q.flag_bits),
    .in_payload_value   (req_q.payload),
    .in_identity        (req_q.identity),
    .in_overflow_payload(req_q.ovf_payload),
    .in_tick            (req_q.tick),
    .in_peek_index      (req_q.peek_index),
    .in_ack_count       (req_q.ack_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_peek_valid     (out_peek_valid),
    .out_stage          (out_stage),
    .out_flags          (out_flags),
    .out_tick           (out_tick),
    .out_value          (out_value),
    .out_pending_count  (out_pending_count),
    .out_dropped_count  (out_dropped_count)
  );

  trace_ring_checker #(
    .DEPTH(RING_DEPTH)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (req_q.kind),
    .in_stage           (req_q.stage),
    .in_flag_bits       (req_q.flag_bits),
    .in_payload_value   (req_q.payload),
    .in_identity        (req_q.identity),
    .in_overflow_payload(req_q.ovf_payload),
    .in_tick            (req_q.tick),
    .in_peek_index      (req_q.peek_index),
    .in_ack_count       (req_q.ack_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_peek_valid     (out_peek_valid),
    .out_stage          (out_stage),
    .out_flags          (out_flags),
    .out_tick           (out_tick),
    .out_value          (out_value),
    .out_pending_count  (out_pending_count),
    .out_dropped_count  (out_dropped_count),
    .end_of_test        (end_of_test),
    .results_due        (results_due),
    .fail_count         (fail_count)
  );

  // every field random, including the ones the kind ignores
  function automatic trace_req_t noise_req();
    trace_req_t r;
    r.kind        = kind_t'($urandom_range(0, 3));
    r.stage       = 8'($urandom);
    r.flag_bits   = 8'($urandom);
    r.payload     = $urandom;
    r.identity    = 16'($urandom);
    r.ovf_payload = 16'($urandom);
    r.tick        = 16'($urandom);
    r.peek_index  = 16'($urandom);
    r.ack_count   = 16'($urandom);
    return r;
  endfunction

  // weighted mix: mostly writes, peeks aimed near the pending window,
  // acknowledges mostly small so the ring stays partly full
  function automatic trace_req_t shaped_req();
    trace_req_t r;
    int         pick;
    r    = noise_req();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.kind = KIND_RECORD;
    end else if (pick < 60) begin
      r.kind = KIND_OVERFLOW;
    end else if (pick < 85) begin
      r.kind = KIND_PEEK;
      if ($urandom_range(0, 9) < 8) r.peek_index = 16'($urandom_range(0, RING_DEPTH + 2));
    end else begin
      r.kind = KIND_ACK;
      pick   = $urandom_range(0, 9);
      if (pick < 7) r.ack_count = 16'($urandom_range(0, 6));
      else if (pick < 9) r.ack_count = 16'($urandom_range(0, RING_DEPTH + 4));
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic issue_request(input trace_req_t r);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_q <= r;
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // sender holds off until every outstanding request has its result
  task automatic drain();
    start <= 1'b0;
    while (results_due != 0) @(posedge clk);
  endtask

  // register writes only with the ring idle
  task automatic write_stage_code(input logic [7:0] code);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    trace_req_t r;
    int         puts;
    int         pick;
    int         waited;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    req_q           <= '0;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    end_of_test     <= 1'b0;
    sender_idle_pct = 12;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // overflow request before any register write sees the reset stage code
    r = noise_req();
    r.kind = KIND_OVERFLOW; r.identity = 16'h0400; r.ovf_payload = 16'hFFFF; r.tick = 16'h0;
    issue_request(r);
    write_stage_code(8'hFF);

    // directed: empty ring, field extremes, peek window edges, acknowledge clamp
    r = noise_req(); r.kind = KIND_PEEK; r.peek_index = 16'd0;      issue_request(r);
    r = noise_req(); r.kind = KIND_ACK;  r.ack_count  = 16'hFFFF;   issue_request(r);
    r = noise_req(); r.kind = KIND_RECORD;
    r.stage = 8'hFF; r.flag_bits = 8'hFF; r.payload = 32'hFFFF_FFFF; r.tick = 16'hFFFF;
    issue_request(r);
    r = noise_req(); r.kind = KIND_RECORD;
    r.stage = 8'h00; r.flag_bits = 8'h00; r.payload = 32'h0; r.tick = 16'h0;
    issue_request(r);
    r = noise_req(); r.kind = KIND_OVERFLOW;
    r.identity = 16'hFFFF; r.ovf_payload = 16'hFFFF; r.tick = 16'hFFFF;
    issue_request(r);
    // every identity bit set except the flag bit
    r = noise_req(); r.kind = KIND_OVERFLOW;
    r.identity = 16'hFBFF; r.ovf_payload = 16'h0000; r.tick = 16'h0;
    issue_request(r);
    // four pending: indexes 0..3 hit, 4 and 5 are past the window
    for (int i = 0; i <= 5; i++) begin
      r = noise_req(); r.kind = KIND_PEEK; r.peek_index = 16'(i); issue_request(r);
    end
    r = noise_req(); r.kind = KIND_PEEK; r.peek_index = 16'hFFFF;   issue_request(r);
    r = noise_req(); r.kind = KIND_ACK;  r.ack_count  = 16'd2;      issue_request(r);
    r = noise_req(); r.kind = KIND_PEEK; r.peek_index = 16'd0;      issue_request(r);
    r = noise_req(); r.kind = KIND_ACK;  r.ack_count  = 16'd0;      issue_request(r);
    r = noise_req(); r.kind = KIND_ACK;  r.ack_count  = 16'hFFFF;   issue_request(r);
    r = noise_req(); r.kind = KIND_PEEK; r.peek_index = 16'd0;      issue_request(r);

    // random, light sender gaps
    write_stage_code(8'($urandom));
    for (int i = 0; i < 550; i++) begin
      issue_request(shaped_req());
      if (i == 275) drain();
    end

    // random, heavy sender gaps, lowest stage code
    sender_idle_pct = 55;
    write_stage_code(8'h00);
    for (int i = 0; i < 550; i++) issue_request(shaped_req());

    // back to back: write burst laps the ring, oldest records keep getting dropped
    sender_idle_pct = 0;
    write_stage_code(8'($urandom));
    puts = 0;
    while (puts < BURST_PUTS) begin
      r    = noise_req();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        r.kind = KIND_PEEK;
        r.peek_index = 16'($urandom_range(0, RING_DEPTH));
      end else begin
        r.kind = (pick < 10) ? KIND_OVERFLOW : KIND_RECORD;
        puts++;
      end
      issue_request(r);
    end
    // after the burst, starting from a full ring with drops counted
    for (int i = 0; i < 300; i++) issue_request(shaped_req());

    // let the last results land, bounded
    start <= 1'b0;
    waited = 0;
    while (results_due != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    end_of_test <= 1'b1;
    @(negedge clk);
    @(posedge clk);

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // hard stop if a handshake never completes
  initial begin : watchdog
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### overwriting_trace_ring_core.f
hdl/otr_pkg.sv
hdl/otr_ram.sv
hdl/otr_queue.sv
hdl/otr_front.sv
hdl/otr_back.sv
hdl/overwriting_trace_ring_core.sv
test/trace_ring_checker.sv
test/testbench.sv
